/* hdl/hcs_pkg.sv */
// Shared constants, types and control structs for the hash-checked stack.
package hcs_pkg;

    // Stack geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int HASH_W = 64;
    localparam int HALF_W = HASH_W / 2;
    localparam int FILL_W = 7;

    // Power of the first position (3^1)
    localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(3);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_FAULT = 2'd3
    } status_t;

    // Request and response payloads
    typedef struct packed {
        op_t                      cmd;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        status_t                  status;
        logic [FILL_W-1:0]        fill_count;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic    take_req;
        logic    issue_read;
        logic    issue_feed;
        logic    do_push;
        logic    do_pop;
        logic    set_fault;
        logic    kept_load;
        logic    load_rsp;
        status_t rsp_status;
    } hcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fault;
        logic is_pop;
        logic empty;
        logic full;
        logic walk_last;
        logic pipe_empty;
        logic hash_match;
    } hcs_stat_t;

endpackage

/* hdl/hcs_dpath.sv */
// Datapath: entry memory, hash walk pipeline, stack state and response register.
module hcs_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  hcs_pkg::req_t     req,
    input  hcs_pkg::hcs_cmd_t cmd,
    output hcs_pkg::hcs_stat_t stat,
    output hcs_pkg::rsp_t     rsp
);

    // Entry storage
    logic [hcs_pkg::WORD_W-1:0] mem [hcs_pkg::DEPTH];

    // Stack state
    logic [hcs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [hcs_pkg::HASH_W-1:0] kept_reg;
    logic                       fault_reg;

    // Captured request
    hcs_pkg::op_t               op_reg;
    logic [hcs_pkg::WORD_W-1:0] val_reg;

    // Walk control
    logic [hcs_pkg::ADDR_W-1:0] idx_reg;
    logic [hcs_pkg::HASH_W-1:0] pow_reg;

    // Stage 1: read data and its power
    logic                       s1_vld_reg;
    logic                       s1_src_val_reg;
    logic [hcs_pkg::WORD_W-1:0] rd_data_reg;
    logic [hcs_pkg::HASH_W-1:0] s1_pow_reg;

    // Stage 2: partial products
    logic                       s2_vld_reg;
    logic [hcs_pkg::HASH_W-1:0] lo_reg;
    logic [hcs_pkg::HALF_W-1:0] hi_reg;
    logic [hcs_pkg::HALF_W-1:0] corr_reg;

    // Stage 3: accumulated hash and last term
    logic [hcs_pkg::HASH_W-1:0] acc_reg;
    logic [hcs_pkg::HASH_W-1:0] term_reg;

    hcs_pkg::rsp_t              rsp_reg;

    // Multiplier operands
    logic [hcs_pkg::WORD_W-1:0] opnd;
    logic [hcs_pkg::HALF_W-1:0] pow_lo;
    logic [hcs_pkg::HALF_W-1:0] pow_hi;
    logic [hcs_pkg::HASH_W-1:0] mul_lo;
    logic [hcs_pkg::HALF_W-1:0] mul_hi;
    logic [hcs_pkg::HASH_W-1:0] term;

    assign opnd   = s1_src_val_reg ? val_reg : rd_data_reg;
    assign pow_lo = s1_pow_reg[hcs_pkg::HALF_W-1:0];
    assign pow_hi = s1_pow_reg[hcs_pkg::HASH_W-1:hcs_pkg::HALF_W];
    assign mul_lo = hcs_pkg::HASH_W'(opnd) * hcs_pkg::HASH_W'(pow_lo);
    // only the low half of the upper product lands below 2^64
    assign mul_hi = opnd * pow_hi;

    // Sign-extended word times 64-bit power, mod 2^64
    assign term = lo_reg + {hi_reg, {hcs_pkg::HALF_W{1'b0}}}
                         - {corr_reg, {hcs_pkg::HALF_W{1'b0}}};

    // Count after the current command
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_push)
        begin
            count_next = count_reg + hcs_pkg::CNT_W'(1);
        end
        else if (cmd.do_pop)
        begin
            count_next = count_reg - hcs_pkg::CNT_W'(1);
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
        begin
            mem[count_reg[hcs_pkg::ADDR_W-1:0]] <= val_reg;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            kept_reg   <= '0;
            fault_reg  <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            s1_vld_reg <= cmd.issue_read | cmd.issue_feed;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.set_fault)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.do_pop)
            begin
                kept_reg <= acc_reg ^ term_reg;
            end
            else if (cmd.kept_load)
            begin
                kept_reg <= acc_reg;
            end
        end
    end

    // Walk pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            op_reg  <= req.cmd;
            val_reg <= req.push_value;
            idx_reg <= '0;
            pow_reg <= hcs_pkg::HASH_SEED;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.issue_read)
            begin
                idx_reg <= idx_reg + hcs_pkg::ADDR_W'(1);
            end
            if (cmd.issue_read || cmd.issue_feed)
            begin
                pow_reg <= pow_reg + {pow_reg[hcs_pkg::HASH_W-2:0], 1'b0};
            end
            if (s2_vld_reg)
            begin
                acc_reg <= acc_reg ^ term;
            end
        end
        if (cmd.issue_read || cmd.issue_feed)
        begin
            s1_pow_reg     <= pow_reg;
            s1_src_val_reg <= cmd.issue_feed;
        end
        if (s1_vld_reg)
        begin
            lo_reg   <= mul_lo;
            hi_reg   <= mul_hi;
            corr_reg <= opnd[hcs_pkg::WORD_W-1] ? pow_lo : '0;
        end
        if (s2_vld_reg)
        begin
            term_reg <= term;
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.pop_value  <= cmd.do_pop ? rd_data_reg : '0;
            rsp_reg.status     <= cmd.rsp_status;
            rsp_reg.fill_count <= hcs_pkg::FILL_W'(count_next);
        end
    end

    assign rsp = rsp_reg;

    // Status toward the controller
    assign stat.fault      = fault_reg;
    assign stat.is_pop     = (op_reg == hcs_pkg::OP_POP);
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == hcs_pkg::CNT_W'(hcs_pkg::DEPTH));
    assign stat.walk_last  = ((hcs_pkg::CNT_W'(idx_reg) + hcs_pkg::CNT_W'(1)) == count_reg);
    assign stat.pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign stat.hash_match = (acc_reg == kept_reg);

endmodule

/* hdl/hcs_ctrl.sv */
// Controller: sequences the hash walk, the check and the stack update per transaction.
module hcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  hcs_pkg::hcs_stat_t stat,
    output hcs_pkg::hcs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_CHECK,
        S_FDRAIN,
        S_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsp_status = hcs_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    if (stat.fault)
                    begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = hcs_pkg::ST_FAULT;
                        state_next     = S_REPLY;
                    end
                    else if (stat.empty)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.issue_read = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_REPLY;
                cmd.load_rsp = 1'b1;
                if (!stat.hash_match)
                begin
                    cmd.set_fault  = 1'b1;
                    cmd.rsp_status = hcs_pkg::ST_FAULT;
                end
                else if (stat.is_pop)
                begin
                    if (stat.empty)
                    begin
                        cmd.rsp_status = hcs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.do_pop = 1'b1;
                    end
                end
                else if (stat.full)
                begin
                    cmd.rsp_status = hcs_pkg::ST_FULL;
                end
                else
                begin
                    // push: hash the new word before answering
                    cmd.load_rsp   = 1'b0;
                    cmd.do_push    = 1'b1;
                    cmd.issue_feed = 1'b1;
                    state_next     = S_FDRAIN;
                end
            end
            S_FDRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.kept_load = 1'b1;
                    cmd.load_rsp  = 1'b1;
                    state_next    = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= (state_next == S_REPLY);
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* hdl/hash_checked_stack.sv */
// Top level of the hash-checked LIFO stack.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  req     | in        | req_valid / req_stall  | cmd, push_value
//  rsp     | out       | rsp_valid / rsp_stall  | pop_value, status, fill_count
//
// A pop or a refused push is answered after the hash walk and the check, and a
// push that is taken also feeds the new word through the pipeline first. The
// hash walk reads the entry memory once per entry held, through a 3-stage
// multiply pipeline; on an empty stack there is no walk. A fault already set
// is answered in the cycle after acceptance.
// One transaction at a time: req_stall is high from acceptance until the
// response has been taken. rsp_stall holds the response register as is.
// Reset empties the stack and clears the hash and the fault; no clearing pass.
module hash_checked_stack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hcs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hcs_pkg::rsp_t rsp
);

    hcs_pkg::hcs_cmd_t  cmd;
    hcs_pkg::hcs_stat_t stat;

    hcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hcs_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

/* hdl/hcs_checker.sv */
// Port-level checks for the hash-checked stack, bound to the top level.
module hcs_port_checks (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input hcs_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input hcs_pkg::rsp_t rsp
);

    // A stalled response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // No new transaction is taken while a response is pending
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request accepted with a response pending");

    // Only a successful pop returns a word
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != hcs_pkg::ST_OK |-> rsp.pop_value == '0)
        else $error("refused transaction returned a word");

    // Empty and full refusals agree with the fill count
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == hcs_pkg::ST_EMPTY |-> rsp.fill_count == '0)
        else $error("empty refusal with nonzero fill count");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == hcs_pkg::ST_FULL
        |-> rsp.fill_count == hcs_pkg::FILL_W'(hcs_pkg::DEPTH))
        else $error("full refusal with wrong fill count");

endmodule

bind hash_checked_stack hcs_port_checks u_hcs_port_checks (.*);

/* tb/hcs_checker.sv */
// Response checker for the hash-checked stack: predicts every response and compares it.
module hcs_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  hcs_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  hcs_pkg::rsp_t rsp,
    output int            error_count,
    output int            outstanding
);

    // Shadow copy of the stack contents and its guard state
    logic signed [hcs_pkg::WORD_W-1:0] shadow_mem [hcs_pkg::DEPTH];
    int unsigned                       shadow_count = 0;
    logic [hcs_pkg::HASH_W-1:0]        shadow_hash  = '0;
    logic                              shadow_fault = 1'b0;

    hcs_pkg::rsp_t expected_rsp_q [$];
    hcs_pkg::rsp_t want;

    // XOR of each sign-extended entry times 3^position, modulo 2^64
    function automatic logic [hcs_pkg::HASH_W-1:0] stack_digest();
        logic [hcs_pkg::HASH_W-1:0] acc;
        logic [hcs_pkg::HASH_W-1:0] pw;
        logic [hcs_pkg::HASH_W-1:0] ext;
        acc = '0;
        pw  = hcs_pkg::HASH_SEED;
        for (int i = 0; i < shadow_count; i++)
        begin
            ext = {{(hcs_pkg::HASH_W - hcs_pkg::WORD_W){shadow_mem[i][hcs_pkg::WORD_W-1]}},
                   shadow_mem[i]};
            acc ^= ext * pw;
            pw = pw * hcs_pkg::HASH_SEED;
        end
        return acc;
    endfunction

    // Apply one command to the shadow stack and return the response it should give
    function automatic hcs_pkg::rsp_t predict_command(input hcs_pkg::req_t r);
        hcs_pkg::rsp_t e;
        e.pop_value = '0;
        e.status    = hcs_pkg::ST_OK;
        if (!shadow_fault && stack_digest() != shadow_hash)
            shadow_fault = 1'b1;
        if (shadow_fault)
            e.status = hcs_pkg::ST_FAULT;
        else if (r.cmd == hcs_pkg::OP_PUSH)
        begin
            if (shadow_count >= hcs_pkg::DEPTH)
                e.status = hcs_pkg::ST_FULL;
            else
            begin
                shadow_mem[shadow_count] = r.push_value;
                shadow_count++;
                shadow_hash = stack_digest();
            end
        end
        else
        begin
            if (shadow_count == 0)
                e.status = hcs_pkg::ST_EMPTY;
            else
            begin
                shadow_count--;
                e.pop_value = shadow_mem[shadow_count];
                shadow_hash = stack_digest();
            end
        end
        e.fill_count = hcs_pkg::FILL_W'(shadow_count);
        return e;
    endfunction

    // Watch both channels; predict on request, compare on response
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_command(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("unexpected response: pop_value %0d status %0d fill_count %0d",
                           rsp.pop_value, rsp.status, rsp.fill_count);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.pop_value !== want.pop_value || rsp.status !== want.status
                        || rsp.fill_count !== want.fill_count)
                        error_count <= error_count + 1;
                    if (rsp.pop_value !== want.pop_value)
                        $error("pop_value: expected %0d, got %0d", want.pop_value, rsp.pop_value);
                    if (rsp.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                    if (rsp.fill_count !== want.fill_count)
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               rsp.fill_count);
                end
            end
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the hash-checked stack: clock, reset, stimulus, watchdog and verdict.
module tb_top;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 375;
    localparam int SETTLE_CYCLES  = 2 * hcs_pkg::DEPTH + 16;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    hcs_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    hcs_pkg::rsp_t rsp;

    int   error_count;
    int   outstanding;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   stack_level  = 0;
    int   sent         = 0;
    int   quiet_cycles = 0;
    logic hold_req     = 1'b0;

    always #2 clk = ~clk;

    hash_checked_stack u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    hcs_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Receiver: random stall per cycle, plus one long hold-off on request
    initial
    begin
        bit held;
        held      = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("FAIL hash_checked_stack");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly random words, with the extremes mixed in
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h00000000;
            3:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request transaction and wait for it to be taken
    task automatic send_cmd(input hcs_pkg::op_t op, input logic signed [31:0] word);
        hcs_pkg::req_t item;
        item.cmd        = op;
        item.push_value = word;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == hcs_pkg::OP_PUSH && stack_level < hcs_pkg::DEPTH)
            stack_level++;
        else if (op == hcs_pkg::OP_POP && stack_level > 0)
            stack_level--;
        sent++;
    endtask

    // Stop offering and wait until every response has come back
    task automatic drain_all();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Push until full, then a few refused pushes
    task automatic run_fill();
        int extra;
        extra = $urandom_range(1, 3);
        while (stack_level < hcs_pkg::DEPTH)
            send_cmd(hcs_pkg::OP_PUSH, pick_word());
        repeat (extra) send_cmd(hcs_pkg::OP_PUSH, pick_word());
    endtask

    // One idling setting: fill first, then fill/drain/mixed runs
    task automatic run_phase(input int idle, input int stall);
        int start;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent;
        run_fill();
        while (sent - start < PHASE_ITEMS)
        begin
            case ($urandom_range(3))
                0: run_fill();
                1:
                begin
                    len = $urandom_range(1, 2);
                    while (stack_level > 0)
                        send_cmd(hcs_pkg::OP_POP, pick_word());
                    repeat (len) send_cmd(hcs_pkg::OP_POP, pick_word());
                end
                default:
                begin
                    len = $urandom_range(5, 40);
                    repeat (len) send_cmd(hcs_pkg::op_t'($urandom_range(1)), pick_word());
                end
            endcase
        end
        drain_all();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop when empty, extreme words, unwind, pop when empty again, then a short push/pop pair
        send_cmd(hcs_pkg::OP_POP,  32'h7fffffff);
        send_cmd(hcs_pkg::OP_PUSH, 32'h7fffffff);
        send_cmd(hcs_pkg::OP_PUSH, 32'h80000000);
        send_cmd(hcs_pkg::OP_PUSH, 32'h00000000);
        send_cmd(hcs_pkg::OP_PUSH, 32'hffffffff);
        send_cmd(hcs_pkg::OP_PUSH, 32'h00000001);
        send_cmd(hcs_pkg::OP_PUSH, 32'h55555555);
        send_cmd(hcs_pkg::OP_PUSH, 32'haaaaaaaa);
        repeat (7) send_cmd(hcs_pkg::OP_POP, 32'h00000000);
        send_cmd(hcs_pkg::OP_POP,  32'hffffffff);
        send_cmd(hcs_pkg::OP_PUSH, 32'h80000001);
        send_cmd(hcs_pkg::OP_PUSH, 32'h7ffffffe);
        send_cmd(hcs_pkg::OP_POP,  32'h12345678);
        send_cmd(hcs_pkg::OP_POP,  32'h00000000);

        // Long receiver hold-off while requests keep coming, then a full pause
        hold_req <= 1'b1;
        repeat (6) send_cmd(hcs_pkg::OP_PUSH, pick_word());
        drain_all();

        run_phase(0, 0);
        run_phase(46, 0);
        run_phase(0, 46);
        run_phase(27, 27);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("PASS hash_checked_stack");
        else
            $display("FAIL hash_checked_stack");
        $finish;
    end

endmodule

/* hash_checked_stack.f */
hdl/hcs_pkg.sv
hdl/hcs_dpath.sv
hdl/hcs_ctrl.sv
hdl/hash_checked_stack.sv
hdl/hcs_checker.sv
tb/hcs_checker.sv
tb/tb_top.sv
